// ===== rtl/core/tlxy_pkg.sv =====
// Shared types, widths and register codes for the tiled LED matrix index mapper.
// Holds the derived-configuration function used by the config block at reset and run time.
// No dependencies.
package tlxy_pkg;

	localparam int unsigned PX_W       = 10;
	localparam int unsigned IDX_W      = 20;
	localparam int unsigned LAYOUT_W   = 4;
	localparam int unsigned SIDE_W     = 7;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned LIM_W      = SIDE_W + COUNT_W;
	localparam int unsigned AREA_W     = 2 * SIDE_W;
	localparam int unsigned CFG_DATA_W = 7;
	localparam int unsigned CFG_ADDR_W = 3;

	localparam int unsigned DEF_MAX_TILE_SIDE  = 64;
	localparam int unsigned DEF_MAX_TILE_COUNT = 16;

	// bit positions within a layout code
	localparam int unsigned LAY_COLUMN  = 0;
	localparam int unsigned LAY_SNAKE   = 1;
	localparam int unsigned LAY_HMIRROR = 2;
	localparam int unsigned LAY_VMIRROR = 3;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_PIXEL_LAYOUT = 3'd0,
		REG_TILE_LAYOUT  = 3'd1,
		REG_TILE_WIDTH   = 3'd2,
		REG_TILE_HEIGHT  = 3'd3,
		REG_TILES_ACROSS = 3'd4,
		REG_TILES_DOWN   = 3'd5
	} tlxy_reg_t;

	typedef struct packed {
		logic [LAYOUT_W-1:0] pixel_layout;
		logic [LAYOUT_W-1:0] tile_layout;
		logic [SIDE_W-1:0]   tile_width;
		logic [SIDE_W-1:0]   tile_height;
		logic [COUNT_W-1:0]  tiles_across;
		logic [COUNT_W-1:0]  tiles_down;
	} tlxy_regs_t;

	// clamped sizes plus the products the datapath needs
	typedef struct packed {
		logic [LAYOUT_W-1:0] pixel_layout;
		logic [LAYOUT_W-1:0] tile_layout;
		logic [SIDE_W-1:0]   tile_w;
		logic [SIDE_W-1:0]   tile_h;
		logic [COUNT_W-1:0]  tiles_x;
		logic [COUNT_W-1:0]  tiles_y;
		logic [LIM_W-1:0]    lim_x;
		logic [LIM_W-1:0]    lim_y;
		logic [AREA_W-1:0]   area;
	} tlxy_cfg_t;

	localparam tlxy_regs_t REGS_RST = '{
		pixel_layout: '0,
		tile_layout:  '0,
		tile_width:   SIDE_W'(16),
		tile_height:  SIDE_W'(16),
		tiles_across: COUNT_W'(1),
		tiles_down:   COUNT_W'(1)
	};

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v,
			input int unsigned hi);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (32'(v) > hi) begin
			r = SIDE_W'(hi);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
			input int unsigned hi);
		logic [COUNT_W-1:0] r;
		if (v == '0) begin
			r = COUNT_W'(1);
		end else if (32'(v) > hi) begin
			r = COUNT_W'(hi);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic tlxy_cfg_t derive_cfg(input tlxy_regs_t regs,
			input int unsigned max_side, input int unsigned max_count);
		tlxy_cfg_t c;
		c.pixel_layout = regs.pixel_layout;
		c.tile_layout  = regs.tile_layout;
		c.tile_w       = clamp_side(regs.tile_width, max_side);
		c.tile_h       = clamp_side(regs.tile_height, max_side);
		c.tiles_x      = clamp_count(regs.tiles_across, max_count);
		c.tiles_y      = clamp_count(regs.tiles_down, max_count);
		c.lim_x        = LIM_W'(c.tile_w) * LIM_W'(c.tiles_x);
		c.lim_y        = LIM_W'(c.tile_h) * LIM_W'(c.tiles_y);
		c.area         = AREA_W'(c.tile_w) * AREA_W'(c.tile_h);
		return c;
	endfunction

endpackage

// ===== rtl/core/tlxy_cfg.sv =====
// Configuration registers and their registered, clamped derivatives.
// Depends on tlxy_pkg.
module tlxy_cfg #(
	parameter int unsigned MAX_TILE_SIDE  = tlxy_pkg::DEF_MAX_TILE_SIDE,
	parameter int unsigned MAX_TILE_COUNT = tlxy_pkg::DEF_MAX_TILE_COUNT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tlxy_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [tlxy_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output tlxy_pkg::tlxy_cfg_t                 cfg
);
	import tlxy_pkg::*;

	tlxy_regs_t regs_q;
	tlxy_regs_t regs_d;
	tlxy_cfg_t  cfg_q;

	always_comb begin
		regs_d = regs_q;
		if (cfg_we) begin
			case (cfg_addr)
				REG_PIXEL_LAYOUT: regs_d.pixel_layout = cfg_wdata[LAYOUT_W-1:0];
				REG_TILE_LAYOUT:  regs_d.tile_layout  = cfg_wdata[LAYOUT_W-1:0];
				REG_TILE_WIDTH:   regs_d.tile_width   = cfg_wdata[SIDE_W-1:0];
				REG_TILE_HEIGHT:  regs_d.tile_height  = cfg_wdata[SIDE_W-1:0];
				REG_TILES_ACROSS: regs_d.tiles_across = cfg_wdata[COUNT_W-1:0];
				REG_TILES_DOWN:   regs_d.tiles_down   = cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REGS_RST;
		end else begin
			regs_q <= regs_d;
		end
	end

	// clamp and precompute limits and tile area together with the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= derive_cfg(REGS_RST, MAX_TILE_SIDE, MAX_TILE_COUNT);
		end else begin
			cfg_q <= derive_cfg(regs_d, MAX_TILE_SIDE, MAX_TILE_COUNT);
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/tlxy_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, narrow quotient.
// Depends on tlxy_pkg; valid for dividends below den * 2**QW.
module tlxy_div #(
	parameter int unsigned QW = 4,
	parameter int unsigned RW = 6
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tlxy_pkg::PX_W-1:0]     num,
	input  logic [tlxy_pkg::SIDE_W-1:0]   den,
	output logic [QW-1:0]                 quo,
	output logic [RW-1:0]                 rem
);
	import tlxy_pkg::*;

	localparam int unsigned DW = (PX_W > SIDE_W + QW) ? PX_W : SIDE_W + QW;

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] quo_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int unsigned B = QW - 1 - k;
		logic [DW-1:0] rem_in;
		logic [DW-1:0] shifted;
		logic [QW-1:0] quo_in;

		if (k == 0) begin : g_first
			assign rem_in = DW'(num);
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		assign shifted = DW'(den) << B;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= shifted) begin
					rem_s[k] <= rem_in - shifted;
					quo_s[k] <= quo_in | (QW'(1) << B);
				end else begin
					rem_s[k] <= rem_in;
					quo_s[k] <= quo_in;
				end
			end
		end
	end

	assign quo = quo_s[QW-1];
	assign rem = RW'(rem_s[QW-1]);

endmodule

// ===== rtl/core/tlxy_map.sv =====
// Two-stage block mapper: mirror and snake fold, then major * extent + minor.
// Depends on tlxy_pkg for the layout bit positions.
module tlxy_map #(
	parameter int unsigned CRD_W = 4,
	parameter int unsigned EXT_W = 5
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [tlxy_pkg::LAYOUT_W-1:0]       layout,
	input  logic [EXT_W-1:0]                    ext_x,
	input  logic [EXT_W-1:0]                    ext_y,
	input  logic [CRD_W-1:0]                    crd_x,
	input  logic [CRD_W-1:0]                    crd_y,
	output logic [2*CRD_W-1:0]                  pos
);
	import tlxy_pkg::*;

	localparam int unsigned MW  = (CRD_W > EXT_W) ? CRD_W : EXT_W;
	localparam int unsigned PRW = CRD_W + EXT_W;

	logic             col, snake, hm, vm;
	logic [CRD_W-1:0] major, minor, major_m, minor_m;
	logic [EXT_W-1:0] major_ext, minor_ext;
	logic             major_mir, minor_mir, flip;

	logic [CRD_W-1:0]   major_s1, minor_s1;
	logic [EXT_W-1:0]   ext_s1;
	logic [2*CRD_W-1:0] pos_s2;

	always_comb begin
		col       = layout[LAY_COLUMN];
		snake     = layout[LAY_SNAKE];
		hm        = layout[LAY_HMIRROR];
		vm        = layout[LAY_VMIRROR];
		major     = col ? crd_x : crd_y;
		minor     = col ? crd_y : crd_x;
		major_ext = col ? ext_x : ext_y;
		minor_ext = col ? ext_y : ext_x;
		major_mir = col ? hm : vm;
		minor_mir = col ? vm : hm;
		major_m   = major_mir ? CRD_W'(MW'(major_ext) - MW'(1) - MW'(major)) : major;
		// odd lines run backwards when snaking
		flip      = minor_mir ^ (snake & major_m[0]);
		minor_m   = flip ? CRD_W'(MW'(minor_ext) - MW'(1) - MW'(minor)) : minor;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			major_s1 <= major_m;
			minor_s1 <= minor_m;
			ext_s1   <= minor_ext;
			pos_s2   <= (2*CRD_W)'(PRW'(major_s1) * PRW'(ext_s1) + PRW'(minor_s1));
		end
	end

	assign pos = pos_s2;

endmodule

// ===== rtl/core/tiled_led_matrix_xy_to_index_core.sv =====
// Tiled LED matrix coordinate to LED string index mapper, top level.
// Input channel: in_valid/in_ready with px_x, px_y. Output channel: out_valid/out_ready
// with led_index and out_of_range. A transfer happens when valid and ready are both high.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (0 pixel layout, 1 tile
// layout, 2 tile width, 3 tile height, 4 tiles across, 5 tiles down); other addresses
// are ignored. Write only while no item is in flight; the clamped values are registered
// with the write and apply from the next transfer on.
// The pipeline has one input register, one divider stage per tile-coordinate bit
// (QW = log2 MAX_TILE_COUNT), two mapping stages, one multiply stage and the output
// register. Throughput is one coordinate per cycle while the output is not stalled.
// When out_ready is low while a result waits, every stage holds and in_ready drops;
// nothing is lost or repeated. A coordinate outside the tile grid yields index zero
// with out_of_range set.
// Reset clears all valid bits and returns the registers to their defaults:
// 16 x 16 pixel tiles, one tile, row order, no snake, no mirror.
module tiled_led_matrix_xy_to_index_core #(
	parameter int unsigned MAX_TILE_SIDE  = tlxy_pkg::DEF_MAX_TILE_SIDE,
	parameter int unsigned MAX_TILE_COUNT = tlxy_pkg::DEF_MAX_TILE_COUNT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tlxy_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [tlxy_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [tlxy_pkg::PX_W-1:0]         px_x,
	input  logic [tlxy_pkg::PX_W-1:0]         px_y,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tlxy_pkg::IDX_W-1:0]        led_index,
	output logic                              out_of_range
);
	import tlxy_pkg::*;

	localparam int unsigned QW    = (MAX_TILE_COUNT > 1) ? $clog2(MAX_TILE_COUNT) : 1;
	localparam int unsigned RW    = (MAX_TILE_SIDE > 1) ? $clog2(MAX_TILE_SIDE) : 1;
	localparam int unsigned LAT   = QW + 5;
	localparam int unsigned PRODW = AREA_W + 2 * QW;

	tlxy_cfg_t cfg;
	logic      en;
	logic      oor_in;

	logic [LAT-1:0] vld_q;
	logic [LAT-1:0] oor_q;

	logic [PX_W-1:0]    x_s1, y_s1;
	logic [QW-1:0]      tx, ty;
	logic [RW-1:0]      rx, ry;
	logic [2*QW-1:0]    tile_pos;
	logic [2*RW-1:0]    offset;
	logic [PRODW-1:0]   prod_s2;
	logic [2*RW-1:0]    offset_s2;
	logic [IDX_W-1:0]   led_index_s3;

	tlxy_cfg #(
		.MAX_TILE_SIDE (MAX_TILE_SIDE),
		.MAX_TILE_COUNT(MAX_TILE_COUNT)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.cfg      (cfg)
	);

	// whole pipeline advances unless a finished result is held
	assign en       = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	assign oor_in   = (LIM_W'(px_x) >= cfg.lim_x) || (LIM_W'(px_y) >= cfg.lim_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_q <= {oor_q[LAT-2:0], oor_in};
			x_s1  <= px_x;
			y_s1  <= px_y;
		end
	end

	tlxy_div #(.QW(QW), .RW(RW)) u_div_x (
		.clk(clk), .en(en), .num(x_s1), .den(cfg.tile_w), .quo(tx), .rem(rx)
	);

	tlxy_div #(.QW(QW), .RW(RW)) u_div_y (
		.clk(clk), .en(en), .num(y_s1), .den(cfg.tile_h), .quo(ty), .rem(ry)
	);

	tlxy_map #(.CRD_W(QW), .EXT_W(COUNT_W)) u_map_tile (
		.clk   (clk),
		.en    (en),
		.layout(cfg.tile_layout),
		.ext_x (cfg.tiles_x),
		.ext_y (cfg.tiles_y),
		.crd_x (tx),
		.crd_y (ty),
		.pos   (tile_pos)
	);

	tlxy_map #(.CRD_W(RW), .EXT_W(SIDE_W)) u_map_pixel (
		.clk   (clk),
		.en    (en),
		.layout(cfg.pixel_layout),
		.ext_x (cfg.tile_w),
		.ext_y (cfg.tile_h),
		.crd_x (rx),
		.crd_y (ry),
		.pos   (offset)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2      <= PRODW'(cfg.area) * PRODW'(tile_pos);
			offset_s2    <= offset;
			// drop the index of a coordinate outside the grid
			led_index_s3 <= oor_q[LAT-2] ? '0 : IDX_W'(prod_s2 + PRODW'(offset_s2));
		end
	end

	assign out_valid    = vld_q[LAT-1];
	assign led_index    = led_index_s3;
	assign out_of_range = oor_q[LAT-1];

`ifndef SYNTH
	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> led_index == '0)
		else $error("out-of-range result carries a non-zero index");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved during a stall");

	a_cfg_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.tile_w != '0 && cfg.tile_h != '0 && cfg.tiles_x != '0 && cfg.tiles_y != '0)
		else $error("clamped tile geometry holds a zero");
`endif

endmodule
